// ===== rtl/core/rolling_zscore_signal_unit_assert.svh =====
// Assertion macros for the rolling z-score signal unit.
// Used by the top level; no dependencies.
`ifndef ROLLING_ZSCORE_SIGNAL_UNIT_ASSERT_SVH
`define ROLLING_ZSCORE_SIGNAL_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define RZS_ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("rzs assertion failed");
`define RZS_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("rzs assertion failed");
`else
`define RZS_ASSERT_IMPL(lbl, clk, rst_n, pre, post)
`define RZS_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

// ===== rtl/core/rzs_pkg.sv =====
// Shared types and constants of the rolling z-score signal unit.
// No dependencies.
`timescale 1ns / 1ps
package rzs_pkg;
  localparam int WINDOW_MAX_DEF = 256;
  localparam int PRICE_BITS_DEF = 24;

  localparam int SYM_W   = 16;
  localparam int PRICE_W = 24;
  localparam int QTY_W   = 20;
  localparam int N_W     = 9;
  localparam int TH_W    = 16;
  localparam int ACT_W   = 2;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam logic [SYM_W-1:0]        SYMBOL_RST = '0;
  localparam logic [N_W-1:0]          WLEN_RST   = 9'd20;
  localparam logic signed [TH_W-1:0]  ENTRY_RST  = -16'sd512;
  localparam logic signed [TH_W-1:0]  EXIT_RST   = '0;
  localparam logic [QTY_W-1:0]        SIZE_RST   = 20'd100;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE = 2'd0,
    ACT_BUY  = 2'd1,
    ACT_SELL = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    REG_SYMBOL = 3'd0,
    REG_WLEN   = 3'd1,
    REG_ENTRY  = 3'd2,
    REG_EXIT   = 3'd3,
    REG_SIZE   = 3'd4
  } reg_idx_e;

  typedef enum logic [3:0] {
    OP_OLDSQ, OP_NEWSQ, OP_NQ, OP_SS, OP_NX, OP_MAG, OP_TE, OP_TX, OP_RE, OP_RX
  } mul_op_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_MUL_GO, ST_MUL_WAIT, ST_UPDATE, ST_CALC_D,
    ST_CALC_MAG, ST_DECIDE, ST_FINISH
  } state_e;

  typedef struct packed {
    logic    load;
    logic    mem_rd;
    logic    mul_start;
    mul_op_e mul_op;
    logic    update;
    logic    calc_d;
    logic    calc_mag;
    logic    decide;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic match;
    logic full_after;
    logic mul_busy;
    logic mul_done;
    logic out_free;
  } sts_t;
endpackage

// ===== rtl/core/rzs_bar_if.sv =====
// Input channel of price bars.
// Depends on rzs_pkg.
`timescale 1ns / 1ps
interface rzs_bar_if import rzs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SYM_W-1:0]   symbol_code;
  logic [PRICE_W-1:0] close_price;
  logic [QTY_W-1:0]   held_quantity;

  modport source (output valid, symbol_code, close_price, held_quantity, input ready);
  modport sink (input valid, symbol_code, close_price, held_quantity, output ready);
endinterface

// ===== rtl/core/rzs_ord_if.sv =====
// Output channel of order results.
// Depends on rzs_pkg.
`timescale 1ns / 1ps
interface rzs_ord_if import rzs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] order_action;
  logic [QTY_W-1:0] order_quantity;
  logic             window_full;

  modport source (output valid, order_action, order_quantity, window_full, input ready);
  modport sink (input valid, order_action, order_quantity, window_full, output ready);
endinterface

// ===== rtl/core/rzs_mul.sv =====
// Shared multi-cycle multiplier: wide operand times 16-bit digits, MSB digit first.
// Depends on rzs_pkg (style only).
`timescale 1ns / 1ps
module rzs_mul import rzs_pkg::*; #(
  parameter int A_W = 66,
  parameter int MUL_DIG = 3
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [A_W-1:0]             a_i,
  input  logic [MUL_DIG*16-1:0]      b_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [A_W+MUL_DIG*16-1:0]  prod_o
);
  localparam int MB_W  = MUL_DIG * 16;
  localparam int P_W   = A_W + MB_W;
  localparam int PP_W  = A_W + 16;
  localparam int CNT_W = $clog2(MUL_DIG + 1);

  logic [A_W-1:0]   a_q;
  logic [MB_W-1:0]  b_q;
  logic [PP_W-1:0]  pp_q, pp_d;
  logic [P_W-1:0]   acc_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;

  assign pp_d = PP_W'(a_q) * PP_W'(b_q[MB_W-1 -: 16]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == CNT_W'(MUL_DIG)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // partial product registered, accumulated in the following cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      if (cnt_q < CNT_W'(MUL_DIG)) begin
        pp_q <= pp_d;
        b_q  <= b_q << 16;
      end
      if (cnt_q != '0) begin
        acc_q <= (acc_q << 16) + P_W'(pp_q);
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign prod_o = acc_q;
endmodule

// ===== rtl/core/rzs_datapath.sv =====
// Datapath: price history memory, running sums, exact z-score threshold compare,
// result and output registers. Depends on rzs_pkg and rzs_mul.
`timescale 1ns / 1ps
module rzs_datapath import rzs_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF,
  parameter int PRICE_BITS = PRICE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  output sts_t                   sts_o,
  input  logic                   clear_i,
  input  logic [SYM_W-1:0]       watched_i,
  input  logic [N_W-1:0]         wlen_i,
  input  logic signed [TH_W-1:0] entry_i,
  input  logic signed [TH_W-1:0] exit_i,
  input  logic [QTY_W-1:0]       size_i,
  input  logic [SYM_W-1:0]       symbol_i,
  input  logic [PRICE_W-1:0]     price_i,
  input  logic [QTY_W-1:0]       held_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [ACT_W-1:0]       out_action_o,
  output logic [QTY_W-1:0]       out_qty_o,
  output logic                   out_full_o
);
  localparam int PB      = PRICE_BITS;
  localparam int SUM_W   = PB + N_W;
  localparam int SQ_W    = 2 * PB + N_W;
  localparam int D_W     = 2 * PB + 2 * N_W;
  localparam int MAG_W   = SUM_W + 8;
  localparam int LHS_W   = 2 * MAG_W;
  localparam int TSQ_W   = 2 * TH_W;
  localparam int RHS_W   = D_W + TSQ_W;
  localparam int B_RAW   = (MAG_W > TSQ_W) ? MAG_W : TSQ_W;
  localparam int MUL_DIG = (B_RAW + 15) / 16;
  localparam int MB_W    = MUL_DIG * 16;
  localparam int A_W     = D_W;
  localparam int P_W     = A_W + MB_W;
  localparam int CMP_W   = (LHS_W > RHS_W) ? LHS_W : RHS_W;
  localparam int SLOT_W  = $clog2(WINDOW_MAX);
  localparam int CW      = (SLOT_W + 1 > N_W) ? SLOT_W + 1 : N_W;

  logic [PB-1:0]     hist_q [WINDOW_MAX];
  logic [PB-1:0]     price_q, old_q;
  logic [QTY_W-1:0]  held_q;
  logic [SUM_W-1:0]  sum_q;
  logic [SQ_W-1:0]   sq_q, oldsq_q, newsq_q;
  logic [N_W-1:0]    fill_q;
  logic [SLOT_W-1:0] slot_q;
  logic [D_W-1:0]    nq_q, ss_q, d_q;
  logic [SUM_W-1:0]  nx_q;
  logic              neg_q;
  logic [MAG_W-1:0]  mag_q;
  logic [LHS_W-1:0]  lhs_q;
  logic [TSQ_W-1:0]  te2_q, tx2_q;
  logic [RHS_W-1:0]  rhse_q, rhsx_q;
  action_e           res_act_q, out_act_q;
  logic [QTY_W-1:0]  res_qty_q, out_qty_q;
  logic              res_full_q, out_full_q, ov_q;

  logic [A_W-1:0]    mul_a;
  logic [MB_W-1:0]   mul_b;
  logic [P_W-1:0]    prod;
  logic              mul_busy, mul_done;
  logic [TH_W-1:0]   te_abs, tx_abs;
  logic              was_full;
  logic [CW-1:0]     slot_inc;
  logic              d_zero, aneg_b, aneg_s, buy_hit, sell_hit;
  logic [CMP_W-1:0]  lhs_c, rhse_c, rhsx_c;

  assign te_abs   = entry_i[TH_W-1] ? TH_W'(-entry_i) : entry_i;
  assign tx_abs   = exit_i[TH_W-1] ? TH_W'(-exit_i) : exit_i;
  assign was_full = fill_q >= wlen_i;
  assign slot_inc = CW'(slot_q) + 1'b1;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_op)
      OP_OLDSQ: begin mul_a = A_W'(old_q);   mul_b = MB_W'(old_q);   end
      OP_NEWSQ: begin mul_a = A_W'(price_q); mul_b = MB_W'(price_q); end
      OP_NQ:    begin mul_a = A_W'(sq_q);    mul_b = MB_W'(wlen_i);  end
      OP_SS:    begin mul_a = A_W'(sum_q);   mul_b = MB_W'(sum_q);   end
      OP_NX:    begin mul_a = A_W'(price_q); mul_b = MB_W'(wlen_i);  end
      OP_MAG:   begin mul_a = A_W'(mag_q);   mul_b = MB_W'(mag_q);   end
      OP_TE:    begin mul_a = A_W'(te_abs);  mul_b = MB_W'(te_abs);  end
      OP_TX:    begin mul_a = A_W'(tx_abs);  mul_b = MB_W'(tx_abs);  end
      OP_RE:    begin mul_a = d_q;           mul_b = MB_W'(te2_q);   end
      OP_RX:    begin mul_a = d_q;           mul_b = MB_W'(tx2_q);   end
      default:  begin mul_a = '0;            mul_b = '0;             end
    endcase
  end

  rzs_mul #(.A_W(A_W), .MUL_DIG(MUL_DIG)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .busy_o  (mul_busy),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  // exact sign-aware compare of n*x - S against t * sqrt(d), squared
  assign d_zero = d_q == '0;
  assign aneg_b = neg_q && (mag_q != '0);
  assign aneg_s = !neg_q && (mag_q != '0);
  assign lhs_c  = CMP_W'(lhs_q);
  assign rhse_c = CMP_W'(rhse_q);
  assign rhsx_c = CMP_W'(rhsx_q);

  always_comb begin
    if (d_zero) begin
      buy_hit = !entry_i[TH_W-1] && (entry_i != '0);
    end else if (!entry_i[TH_W-1]) begin
      buy_hit = aneg_b || ((entry_i != '0) && (lhs_c < rhse_c));
    end else begin
      buy_hit = aneg_b && (lhs_c > rhse_c);
    end
    // sell threshold is the negated exit level, tested on the negated deviation
    if (d_zero) begin
      sell_hit = exit_i[TH_W-1];
    end else if (exit_i[TH_W-1] || (exit_i == '0)) begin
      sell_hit = aneg_s || ((exit_i != '0) && (lhs_c < rhsx_c));
    end else begin
      sell_hit = aneg_s && (lhs_c > rhsx_c);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      slot_q <= '0;
      sum_q  <= '0;
      sq_q   <= '0;
      ov_q   <= 1'b0;
    end else begin
      if (clear_i) begin
        fill_q <= '0;
        slot_q <= '0;
        sum_q  <= '0;
        sq_q   <= '0;
      end else if (cmd_i.update) begin
        sum_q  <= sum_q + SUM_W'(price_q) - (was_full ? SUM_W'(old_q) : '0);
        sq_q   <= sq_q + newsq_q - (was_full ? oldsq_q : '0);
        fill_q <= was_full ? fill_q : fill_q + 1'b1;
        slot_q <= (slot_inc >= CW'(wlen_i)) ? '0 : SLOT_W'(slot_inc);
      end
      if (cmd_i.out_load) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      hist_q[slot_q] <= price_q;
    end
    if (cmd_i.mem_rd) begin
      old_q <= hist_q[slot_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      price_q    <= price_i[PB-1:0];
      held_q     <= held_i;
      res_act_q  <= ACT_NONE;
      res_qty_q  <= '0;
      res_full_q <= was_full;
    end
    if (cmd_i.update) begin
      res_act_q  <= ACT_NONE;
      res_qty_q  <= '0;
      res_full_q <= 1'b0;
    end
    if (cmd_i.calc_d) begin
      d_q <= nq_q - ss_q;
    end
    if (cmd_i.calc_mag) begin
      neg_q <= nx_q < sum_q;
      mag_q <= (nx_q < sum_q) ? MAG_W'(sum_q - nx_q) << 8 : MAG_W'(nx_q - sum_q) << 8;
    end
    if (cmd_i.decide) begin
      res_full_q <= 1'b1;
      if ((held_q == '0) && buy_hit) begin
        res_act_q <= ACT_BUY;
        res_qty_q <= size_i;
      end else if ((held_q != '0) && sell_hit) begin
        res_act_q <= ACT_SELL;
        res_qty_q <= held_q;
      end else begin
        res_act_q <= ACT_NONE;
        res_qty_q <= '0;
      end
    end
    if (mul_done) begin
      case (cmd_i.mul_op)
        OP_OLDSQ: oldsq_q <= SQ_W'(prod);
        OP_NEWSQ: newsq_q <= SQ_W'(prod);
        OP_NQ:    nq_q    <= D_W'(prod);
        OP_SS:    ss_q    <= D_W'(prod);
        OP_NX:    nx_q    <= SUM_W'(prod);
        OP_MAG:   lhs_q   <= LHS_W'(prod);
        OP_TE:    te2_q   <= TSQ_W'(prod);
        OP_TX:    tx2_q   <= TSQ_W'(prod);
        OP_RE:    rhse_q  <= RHS_W'(prod);
        OP_RX:    rhsx_q  <= RHS_W'(prod);
        default:  ;
      endcase
    end
    if (cmd_i.out_load) begin
      out_act_q  <= res_act_q;
      out_qty_q  <= res_qty_q;
      out_full_q <= res_full_q;
    end
  end

  assign sts_o.match      = symbol_i == watched_i;
  assign sts_o.full_after = was_full || ((fill_q + 1'b1) >= wlen_i);
  assign sts_o.mul_busy   = mul_busy;
  assign sts_o.mul_done   = mul_done;
  assign sts_o.out_free   = !ov_q || out_ready_i;

  assign out_valid_o  = ov_q;
  assign out_action_o = out_act_q;
  assign out_qty_o    = out_qty_q;
  assign out_full_o   = out_full_q;
endmodule

// ===== rtl/core/rzs_ctrl.sv =====
// Controller state machine: sequences memory read, multiplies, update and decision.
// Depends on rzs_pkg.
`timescale 1ns / 1ps
module rzs_ctrl import rzs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);
  state_e  state_q, state_d;
  mul_op_e op_q, op_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_OLDSQ;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d    = OP_OLDSQ;
          state_d = sts_i.match ? ST_READ : ST_FINISH;
        end
      end
      ST_READ:   state_d = ST_MUL_GO;
      ST_MUL_GO: state_d = ST_MUL_WAIT;
      ST_MUL_WAIT: begin
        if (sts_i.mul_done) begin
          case (op_q)
            OP_OLDSQ: begin op_d = OP_NEWSQ; state_d = ST_MUL_GO; end
            OP_NEWSQ: state_d = ST_UPDATE;
            OP_NQ:    begin op_d = OP_SS; state_d = ST_MUL_GO; end
            OP_SS:    state_d = ST_CALC_D;
            OP_NX:    state_d = ST_CALC_MAG;
            OP_MAG:   begin op_d = OP_TE; state_d = ST_MUL_GO; end
            OP_TE:    begin op_d = OP_TX; state_d = ST_MUL_GO; end
            OP_TX:    begin op_d = OP_RE; state_d = ST_MUL_GO; end
            OP_RE:    begin op_d = OP_RX; state_d = ST_MUL_GO; end
            OP_RX:    state_d = ST_DECIDE;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_UPDATE: begin
        if (sts_i.full_after) begin
          op_d    = OP_NQ;
          state_d = ST_MUL_GO;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_CALC_D: begin
        op_d    = OP_NX;
        state_d = ST_MUL_GO;
      end
      ST_CALC_MAG: begin
        op_d    = OP_MAG;
        state_d = ST_MUL_GO;
      end
      ST_DECIDE: state_d = ST_FINISH;
      ST_FINISH: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.mul_op = op_q;
    in_ready_o   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_READ:     cmd_o.mem_rd = 1'b1;
      ST_MUL_GO:   cmd_o.mul_start = 1'b1;
      ST_MUL_WAIT: ;
      ST_UPDATE:   cmd_o.update = 1'b1;
      ST_CALC_D:   cmd_o.calc_d = 1'b1;
      ST_CALC_MAG: cmd_o.calc_mag = 1'b1;
      ST_DECIDE:   cmd_o.decide = 1'b1;
      ST_FINISH:   cmd_o.out_load = sts_i.out_free;
      default:     ;
    endcase
  end
endmodule

// ===== rtl/core/rolling_zscore_signal_unit.sv =====
// Rolling z-score mean-reversion signal unit. One bar is taken per transfer on
// bar_i and exactly one result leaves on ord_o; the unit works on one bar at a
// time, while a finished result may still wait in the output register. A bar for
// another symbol needs no multiply, a matching bar that does not yet fill the
// window two, and an evaluated bar ten, all through one shared multiplier that
// consumes a 16-bit digit per cycle, with ceil(max(PRICE_BITS + 17, 32) / 16)
// digits per multiply. The z-score test is exact (squared, sign-aware). Registers
// sit on an APB port at 4*index; writing the window length (saturated to
// 1..WINDOW_MAX) clears the history.
`timescale 1ns / 1ps
`include "rolling_zscore_signal_unit_assert.svh"
module rolling_zscore_signal_unit import rzs_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF,
  parameter int PRICE_BITS = PRICE_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  rzs_bar_if.sink           bar_i,
  rzs_ord_if.source         ord_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);
  logic [SYM_W-1:0]       watched_q;
  logic [N_W-1:0]         wlen_q;
  logic signed [TH_W-1:0] entry_q, exit_q;
  logic [QTY_W-1:0]       size_q;
  logic                   wr_en, clear;
  reg_idx_e               idx;
  logic [N_W-1:0]         wlen_raw;
  cmd_t                   cmd;
  sts_t                   sts;

  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite && pready;
  assign idx      = reg_idx_e'(paddr[4:2]);
  assign wlen_raw = pwdata[N_W-1:0];
  assign clear    = wr_en && (idx == REG_WLEN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      watched_q <= SYMBOL_RST;
      wlen_q    <= WLEN_RST;
      entry_q   <= ENTRY_RST;
      exit_q    <= EXIT_RST;
      size_q    <= SIZE_RST;
    end else if (wr_en) begin
      case (idx)
        REG_SYMBOL: watched_q <= pwdata[SYM_W-1:0];
        REG_WLEN: begin
          if (wlen_raw == '0) begin
            wlen_q <= N_W'(1);
          end else if (DATA_W'(wlen_raw) > DATA_W'(WINDOW_MAX)) begin
            wlen_q <= N_W'(WINDOW_MAX);
          end else begin
            wlen_q <= wlen_raw;
          end
        end
        REG_ENTRY: entry_q <= pwdata[TH_W-1:0];
        REG_EXIT:  exit_q  <= pwdata[TH_W-1:0];
        REG_SIZE:  size_q  <= pwdata[QTY_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SYMBOL: prdata = DATA_W'(watched_q);
      REG_WLEN:   prdata = DATA_W'(wlen_q);
      REG_ENTRY:  prdata = DATA_W'(entry_q);
      REG_EXIT:   prdata = DATA_W'(exit_q);
      REG_SIZE:   prdata = DATA_W'(size_q);
      default:    prdata = '0;
    endcase
  end

  rzs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (bar_i.valid),
    .in_ready_o (bar_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rzs_datapath #(.WINDOW_MAX(WINDOW_MAX), .PRICE_BITS(PRICE_BITS)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .clear_i      (clear),
    .watched_i    (watched_q),
    .wlen_i       (wlen_q),
    .entry_i      (entry_q),
    .exit_i       (exit_q),
    .size_i       (size_q),
    .symbol_i     (bar_i.symbol_code),
    .price_i      (bar_i.close_price),
    .held_i       (bar_i.held_quantity),
    .out_valid_o  (ord_o.valid),
    .out_ready_i  (ord_o.ready),
    .out_action_o (ord_o.order_action),
    .out_qty_o    (ord_o.order_quantity),
    .out_full_o   (ord_o.window_full)
  );

  `RZS_ASSERT_NEXT(a_one_bar_at_a_time, clk_i, rst_ni, bar_i.valid && bar_i.ready, !bar_i.ready)
  `RZS_ASSERT_IMPL(a_mul_not_restarted, clk_i, rst_ni, cmd.mul_start, !sts.mul_busy)
  `RZS_ASSERT_IMPL(a_no_result_overwrite, clk_i, rst_ni, cmd.out_load, !ord_o.valid || ord_o.ready)
  `RZS_ASSERT_NEXT(a_result_follows_load, clk_i, rst_ni, cmd.out_load, ord_o.valid)
endmodule
